FILE: hdl/csx_pkg.sv
// csx_pkg: shared types, constants and helpers for the CAN signal decoder.
// Used by csx_field, csx_sat_add, can_signal_extract_scale_top and csx_checker.
package csx_pkg;

  localparam int unsigned PayloadW  = 64;
  localparam int unsigned PosW      = 6;
  localparam int unsigned MaxLen    = 32;
  localparam int unsigned RawW      = 33;
  localparam int unsigned FactorW   = 32;
  localparam int unsigned OffsetW   = 48;
  localparam int unsigned ScaledW   = 64;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned OutDataW  = 104;  // 64 + 33 bits, padded to bytes
  localparam int unsigned ByteW     = 8;

  localparam logic [PosW-1:0]    StartBitRst  = 6'd0;
  localparam logic [PosW-1:0]    FieldLenRst  = 6'd8;
  localparam logic [FactorW-1:0] FactorRst    = 32'h0001_0000;
  localparam logic [OffsetW-1:0] OffsetRst    = 48'h0;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_START_BIT  = 3'd0,
    CFG_FIELD_LEN  = 3'd1,
    CFG_SIGNED     = 3'd2,
    CFG_BIG_ENDIAN = 3'd3,
    CFG_FACTOR     = 3'd4,
    CFG_OFFSET     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0]    start_bit;
    logic [PosW-1:0]    field_length;
    logic               signed_mode;
    logic               big_endian_mode;
    logic [FactorW-1:0] scale_factor;
    logic [OffsetW-1:0] scale_offset;
  } csx_cfg_t;

  // Mirror bit order inside each byte (Motorola numbering).
  function automatic logic [PayloadW-1:0] swap_in_bytes(input logic [PayloadW-1:0] p);
    logic [PayloadW-1:0] q;
    for (int k = 0; k < PayloadW / ByteW; k++) begin
      for (int j = 0; j < ByteW; j++) begin
        q[k*ByteW + j] = p[k*ByteW + (ByteW - 1 - j)];
      end
    end
    return q;
  endfunction

endpackage

FILE: hdl/csx_field.sv
// csx_field: masks the shifted field to its length, restores MSB-first order for
// big-endian fields and sign-extends signed fields. Combinational; depends on csx_pkg.
module csx_field (
  input  csx_pkg::csx_cfg_t                cfg_i,
  input  logic [csx_pkg::MaxLen-1:0]       bits_i,
  output logic [csx_pkg::RawW-1:0]         raw_o
);

  logic [csx_pkg::PosW-1:0]   len_c;
  logic [csx_pkg::MaxLen-1:0] mask;
  logic [csx_pkg::MaxLen-1:0] masked;
  logic [csx_pkg::MaxLen-1:0] rev;
  logic [csx_pkg::MaxLen-1:0] val;
  logic [csx_pkg::PosW-1:0]   rsh;
  logic [csx_pkg::PosW-1:0]   top_idx;
  logic                       sign_bit;

  always_comb begin
    len_c = (cfg_i.field_length > csx_pkg::PosW'(csx_pkg::MaxLen))
          ? csx_pkg::PosW'(csx_pkg::MaxLen) : cfg_i.field_length;
    if (len_c >= csx_pkg::PosW'(csx_pkg::MaxLen)) begin
      mask = '1;
    end else begin
      mask = (csx_pkg::MaxLen'(1) << len_c[4:0]) - csx_pkg::MaxLen'(1);
    end
    masked = bits_i & mask;
    for (int i = 0; i < csx_pkg::MaxLen; i++) begin
      rev[i] = masked[csx_pkg::MaxLen-1-i];
    end
    // first bit in stream is the MSB: reverse, then right-align
    rsh = csx_pkg::PosW'(csx_pkg::MaxLen) - len_c;
    val = cfg_i.big_endian_mode ? (rev >> rsh) : masked;
    top_idx  = len_c - csx_pkg::PosW'(1);
    sign_bit = cfg_i.signed_mode && (len_c != '0) && val[top_idx[4:0]];
    raw_o = sign_bit ? {1'b1, val | ~mask} : {1'b0, val};
  end

endmodule

FILE: hdl/csx_sat_add.sv
// csx_sat_add: adds the Q.16 offset to the product and clips to 64 bits.
// Combinational; depends on csx_pkg.
module csx_sat_add (
  input  logic [csx_pkg::ScaledW-1:0] prod_i,
  input  logic [csx_pkg::OffsetW-1:0] offset_i,
  output logic [csx_pkg::ScaledW-1:0] sum_o,
  output logic                        sat_o
);

  logic [csx_pkg::ScaledW:0] sum_wide;

  always_comb begin
    sum_wide = {prod_i[csx_pkg::ScaledW-1], prod_i}
             + {{(csx_pkg::ScaledW + 1 - csx_pkg::OffsetW){offset_i[csx_pkg::OffsetW-1]}},
                offset_i};
    sat_o = sum_wide[csx_pkg::ScaledW] ^ sum_wide[csx_pkg::ScaledW-1];
    if (!sat_o) begin
      sum_o = sum_wide[csx_pkg::ScaledW-1:0];
    end else if (sum_wide[csx_pkg::ScaledW]) begin
      sum_o = {1'b1, {(csx_pkg::ScaledW-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(csx_pkg::ScaledW-1){1'b1}}};
    end
  end

endmodule

FILE: hdl/can_signal_extract_scale_top.sv
// CAN signal decode: extract a configured field from an 8-byte payload and scale it.
// Every stage below is registered; one request per cycle while the output is not stalled.
// Stages: byte-order shift, mask/reverse/sign-extend, 33x32 multiply, offset add + clip.
// A stall on the output holds every stage in place; nothing is dropped or repeated.
// Reset (rst_ni low, async) empties the pipeline and loads default config
// (start 0, length 8, unsigned, little-endian, factor 1.0, offset 0).
module can_signal_extract_scale_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csx_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [csx_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [csx_pkg::PayloadW-1:0]     s_axis_tdata,   // [63:0] payload
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [csx_pkg::OutDataW-1:0]     m_axis_tdata,   // [63:0] scaled_value,
                                                           // [96:64] raw_value, rest 0
  output logic [0:0]                       m_axis_tuser    // [0] saturated
);

  csx_pkg::csx_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_bit       <= csx_pkg::StartBitRst;
      cfg_q.field_length    <= csx_pkg::FieldLenRst;
      cfg_q.signed_mode     <= 1'b0;
      cfg_q.big_endian_mode <= 1'b0;
      cfg_q.scale_factor    <= csx_pkg::FactorRst;
      cfg_q.scale_offset    <= csx_pkg::OffsetRst;
    end else if (cfg_we_i) begin
      case (csx_pkg::cfg_idx_e'(cfg_addr_i))
        csx_pkg::CFG_START_BIT:  cfg_q.start_bit       <= cfg_wdata_i[csx_pkg::PosW-1:0];
        csx_pkg::CFG_FIELD_LEN:  cfg_q.field_length    <= cfg_wdata_i[csx_pkg::PosW-1:0];
        csx_pkg::CFG_SIGNED:     cfg_q.signed_mode     <= cfg_wdata_i[0];
        csx_pkg::CFG_BIG_ENDIAN: cfg_q.big_endian_mode <= cfg_wdata_i[0];
        csx_pkg::CFG_FACTOR:     cfg_q.scale_factor    <= cfg_wdata_i[csx_pkg::FactorW-1:0];
        csx_pkg::CFG_OFFSET:     cfg_q.scale_offset    <= cfg_wdata_i[csx_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: bring the field to bit 0; positions past 63 shift in zeros
  logic [csx_pkg::PayloadW-1:0] ordered;
  logic [csx_pkg::PayloadW-1:0] shifted;
  logic [csx_pkg::MaxLen-1:0]   s1_bits_d, s1_bits_q;

  assign ordered   = cfg_q.big_endian_mode ? csx_pkg::swap_in_bytes(s_axis_tdata)
                                           : s_axis_tdata;
  assign shifted   = ordered >> cfg_q.start_bit;
  assign s1_bits_d = shifted[csx_pkg::MaxLen-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_bits_q <= s1_bits_d;
  end

  // stage 2: raw value
  logic [csx_pkg::RawW-1:0] s2_raw_d, s2_raw_q;

  csx_field u_field (
    .cfg_i  (cfg_q),
    .bits_i (s1_bits_q),
    .raw_o  (s2_raw_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_raw_q <= s2_raw_d;
  end

  // stage 3: product, always fits in 64 bits
  logic signed [csx_pkg::RawW-1:0]      raw_s;
  logic signed [csx_pkg::FactorW-1:0]   fac_s;
  logic signed [csx_pkg::ScaledW:0]     prod_full;
  logic [csx_pkg::ScaledW-1:0]          s3_prod_q;
  logic [csx_pkg::RawW-1:0]             s3_raw_q;

  assign raw_s     = s2_raw_q;
  assign fac_s     = cfg_q.scale_factor;
  assign prod_full = raw_s * fac_s;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_prod_q <= prod_full[csx_pkg::ScaledW-1:0];
      s3_raw_q  <= s2_raw_q;
    end
  end

  // stage 4: offset and clip, output register
  logic [csx_pkg::ScaledW-1:0] sum_d, s4_sum_q;
  logic                        sat_d, s4_sat_q;
  logic [csx_pkg::RawW-1:0]    s4_raw_q;

  csx_sat_add u_sat_add (
    .prod_i   (s3_prod_q),
    .offset_i (cfg_q.scale_offset),
    .sum_o    (sum_d),
    .sat_o    (sat_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_sum_q <= sum_d;
      s4_sat_q <= sat_d;
      s4_raw_q <= s3_raw_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(csx_pkg::OutDataW - csx_pkg::ScaledW - csx_pkg::RawW){1'b0}},
                          s4_raw_q, s4_sum_q};
  assign m_axis_tuser  = s4_sat_q;

endmodule

FILE: hdl/csx_checker.sv
// csx_checker: port-level checks for can_signal_extract_scale_top, bound below.
// Depends on csx_pkg for widths.
module csx_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [csx_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  // clipped results sit exactly on a 64-bit limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF ||
       m_axis_tdata[63:0] == 64'h8000_0000_0000_0000))
    else $error("saturated flag without a clipped value");

  // a negative raw value came from at most 32 bits, so bit 31 follows the sign
  a_raw_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[96]) |-> m_axis_tdata[95])
    else $error("raw value sign bit not extended");

  // an empty output stage means every stage can take a request
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // stalled output request holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output request changed while stalled");

endmodule

bind can_signal_extract_scale_top csx_checker u_csx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
